// File: rtl/sensor_table_update_core_assert.svh
// Assertion macros for the sensor table update core.
// Depends on nothing; included by the top-level module.
`ifndef SENSOR_TABLE_UPDATE_CORE_ASSERT_SVH
`define SENSOR_TABLE_UPDATE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define STU_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Condition checked in the cycle after a trigger.
`define STU_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/stu_pkg.sv
// Package for the sensor table update core: table size, index and count widths,
// the sequencer state type and the table entry type. Depends on nothing.
package stu_pkg;
    localparam int Entries  = 16;
    localparam int IdxW     = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int CntW     = $clog2(Entries + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_AGE, ST_RD, ST_UPD, ST_OUT
    } stu_state_t;

    // One table entry, kept whole in a single memory word.
    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] id;
        logic [15:0] pressure;
        logic [7:0]  temp;
        logic [7:0]  flags;
        logic [7:0]  bits;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
        logic [31:0] frames;
        logic [15:0] signal;
        logic [15:0] peak;
        logic [31:0] peak_seen;
    } stu_entry_t;
endpackage

// File: rtl/sensor_table_update_core.sv
// Sensor table update core: one transfer in gives one result transfer out.
// A hit is found by walking the used entries; a miss with room appends at slot used;
// a miss on a full table walks all entries to find the oldest one and evicts it.
// The core takes one frame at a time, as the table walk uses the single read
// port; the next frame is taken in the cycle after the result transfer.
// Reset (aresetn low, synchronous) marks the table empty, sets hold to 10000 ticks.
module sensor_table_update_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // proto_code[7:0], sensor_id[39:8], present_bits[47:40],
    // pressure_reading[63:48], temperature_reading[71:64], frame_flags[79:72],
    // signal_strength[95:80], rx_time[127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[3:0], was_new[4], was_evicted[5], sensor_frames[37:6],
    // peak_strength[53:38], merged_bits[61:54], zero fill above
    output logic [63:0]  m_tdata
);
    import stu_pkg::*;

    stu_entry_t            mem [Entries];
    stu_entry_t            rd_q;
    logic [IdxW-1:0]       rd_addr;
    logic                  wr_en;
    stu_entry_t            wr_data;

    stu_state_t            state_reg, state_next;
    logic [127:0]          frm_reg;
    logic [CntW-1:0]       used_reg;
    logic [31:0]           total_reg;
    logic [31:0]           hold_reg;
    logic [CntW-1:0]       ptr_reg, ptr_next;     // address being issued
    logic                  pend_reg, pend_next;   // a read is in flight
    logic [IdxW-1:0]       pidx_reg, pidx_next;   // address of that read
    logic [IdxW-1:0]       idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic                  evict_reg, evict_next;
    logic [31:0]           worst_reg, worst_next;
    logic [63:0]           out_reg;
    logic                  used_inc;

    // Frame fields.
    logic [7:0]  f_proto, f_bits, f_temp, f_flags;
    logic [31:0] f_id, f_tick;
    logic [15:0] f_pres, f_sig;
    assign f_proto = frm_reg[7:0];
    assign f_id    = frm_reg[39:8];
    assign f_bits  = frm_reg[47:40];
    assign f_pres  = frm_reg[63:48];
    assign f_temp  = frm_reg[71:64];
    assign f_flags = frm_reg[79:72];
    assign f_sig   = frm_reg[95:80];
    assign f_tick  = frm_reg[127:96];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // Merge of the frame into the entry read back from the table.
    stu_entry_t  base, upd;
    logic [31:0] age;
    always_comb begin
        base = rd_q;
        if (!found_reg) begin
            base            = '0;
            base.proto      = f_proto;
            base.id         = f_id;
            base.first_seen = f_tick;
            base.peak       = f_sig;
            base.peak_seen  = f_tick;
        end
        upd = base;
        if (f_bits[0]) upd.pressure = f_pres;
        if (f_bits[1]) upd.temp = f_temp;
        upd.bits = base.bits | f_bits;
        if (f_bits[2]) upd.bits[3] = f_bits[3];
        upd.flags     = f_flags;
        upd.signal    = f_sig;
        upd.frames    = base.frames + 32'd1;
        upd.last_seen = f_tick;
        if (($signed(f_sig) >= $signed(base.peak)) ||
            ((f_tick - base.peak_seen) > hold_reg)) begin
            upd.peak      = f_sig;
            upd.peak_seen = f_tick;
        end
        age = f_tick - rd_q.last_seen;
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        evict_next = evict_reg;
        worst_next = worst_reg;
        rd_addr    = ptr_reg[IdxW-1:0];
        wr_en      = 1'b0;
        wr_data    = upd;
        used_inc   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                    ptr_next   = '0;
                    found_next = 1'b0;
                    evict_next = 1'b0;
                end
            end
            ST_SCAN: begin
                // Compare the word read last cycle while issuing the next.
                if (pend_reg && rd_q.proto == f_proto && rd_q.id == f_id) begin
                    found_next = 1'b1;
                    idx_next   = pidx_reg;
                    rd_addr    = pidx_reg;
                    state_next = ST_RD;
                end else if (ptr_reg < used_reg) begin
                    pend_next  = 1'b1;
                    pidx_next  = ptr_reg[IdxW-1:0];
                    ptr_next   = ptr_reg + 1'b1;
                end else if (used_reg < CntW'(Entries)) begin
                    idx_next   = used_reg[IdxW-1:0];
                    used_inc   = 1'b1;
                    state_next = ST_UPD;
                end else begin
                    evict_next = 1'b1;
                    worst_next = '0;
                    ptr_next   = '0;
                    state_next = ST_AGE;
                end
            end
            ST_AGE: begin
                if (pend_reg && age >= worst_reg) begin
                    worst_next = age;
                    idx_next   = pidx_reg;
                end
                if (ptr_reg < CntW'(Entries)) begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IdxW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_UPD;
                end
            end
            ST_RD: begin
                rd_addr    = idx_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                wr_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            total_reg <= '0;
            hold_reg  <= 32'd10000;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (used_inc) used_reg <= used_reg + 1'b1;
            if (wr_en) total_reg <= total_reg + 32'd1;
            if (cfg_wr_en) hold_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        pidx_reg  <= pidx_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        evict_reg <= evict_next;
        worst_reg <= worst_next;
        if (s_tvalid && s_tready) frm_reg <= s_tdata;
        if (wr_en) begin
            out_reg <= {2'b00, upd.bits, upd.peak, upd.frames, evict_reg,
                        ~found_reg, 4'(idx_reg)};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    `include "sensor_table_update_core_assert.svh"
    `STU_ASSERT_IMP(a_used_bound, aclk, aresetn, 1'b1, used_reg <= CntW'(Entries))
    `STU_ASSERT_NEXT(a_wr_then_out, aclk, aresetn, wr_en, m_tvalid)
    `STU_ASSERT_IMP(a_evict_miss, aclk, aresetn, m_tvalid && evict_reg, !found_reg)
endmodule
